// ----- src/igc_pkg.sv -----
package igc_pkg;

	localparam int DEF_NODES       = 8;
	localparam int DEF_WEIGHT_BITS = 16;

	localparam int IDX_W    = 3;
	localparam int IDX_SPAN = 1 << IDX_W;
	localparam int MASK_W   = 8;
	localparam int WEIGHT_W = 16;
	localparam int COLOR_W  = 3;

	typedef struct packed {
		logic [IDX_W-1:0]    node_index;
		logic [MASK_W-1:0]   neighbor_mask;
		logic [WEIGHT_W-1:0] node_weight;
		logic                last_node;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   out_node;
		logic [COLOR_W-1:0] node_color;
		logic               last_result;
	} result_t;

	typedef struct packed {
		logic load;
		logic start;
		logic rotate;
		logic pick;
		logic drain;
	} cell_ctl_t;

endpackage

// ----- src/igc_cell.sv -----
module igc_cell #(
	parameter int NODES       = igc_pkg::DEF_NODES,
	parameter int WEIGHT_BITS = igc_pkg::DEF_WEIGHT_BITS,
	parameter int CELL        = 0
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  igc_pkg::cell_ctl_t                       ctl,
	input  igc_pkg::item_t                           item,
	input  logic [$clog2(NODES)-1:0]                 round,
	input  logic [((NODES < igc_pkg::MASK_W) ? NODES : igc_pkg::MASK_W)-1:0] left_row,
	input  logic [WEIGHT_BITS-1:0]                   left_weight,
	output logic [((NODES < igc_pkg::MASK_W) ? NODES : igc_pkg::MASK_W)-1:0] row,
	output logic [WEIGHT_BITS-1:0]                   weight,
	input  logic [$clog2(NODES)-1:0]                 right_color,
	output logic [$clog2(NODES)-1:0]                 color,
	output logic                                     pick
);

	localparam int ROW_W = (NODES < igc_pkg::MASK_W) ? NODES : igc_pkg::MASK_W;
	localparam int CW    = $clog2(NODES);

	logic [ROW_W-1:0]       row_q;
	logic [WEIGHT_BITS-1:0] weight_q;
	logic [WEIGHT_BITS-1:0] nmax_q;
	logic [CW-1:0]          color_q;
	logic                   sel;
	logic                   hit;

	generate
		if (CELL < igc_pkg::IDX_SPAN) begin : g_sel
			assign sel = ctl.load && (item.node_index == igc_pkg::IDX_W'(CELL));
		end else begin : g_nosel
			assign sel = 1'b0;
		end
		if (CELL < ROW_W) begin : g_hit
			assign hit = row_q[CELL];
		end else begin : g_nohit
			assign hit = 1'b0;
		end
	endgenerate

	assign pick = weight_q > nmax_q;

	// row/weight circulate around the ring; data is back home after NODES shifts
	always_ff @(posedge clk) begin
		if (sel) begin
			row_q    <= ROW_W'(item.neighbor_mask);
			weight_q <= WEIGHT_BITS'(item.node_weight);
		end else if (ctl.rotate) begin
			row_q    <= left_row;
			weight_q <= left_weight;
		end else if (ctl.pick && pick) begin
			weight_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start || ctl.pick) begin
			nmax_q <= '0;
		end else if (ctl.rotate && hit && (weight_q > nmax_q)) begin
			nmax_q <= weight_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= '0;
		end else if (ctl.start) begin
			color_q <= '0;
		end else if (ctl.pick && pick) begin
			color_q <= round;
		end else if (ctl.drain) begin
			color_q <= right_color;
		end
	end

	assign row    = row_q;
	assign weight = weight_q;
	assign color  = color_q;

endmodule

// ----- src/independent_set_graph_coloring.sv -----
// Load transactions: one per cycle in the idle state, no result.
// Coloring after the last load: up to NODES-1 rounds, each a rotate phase
// (the ring of cells needs NODES shifts per round) followed by a pick state.
// Results: NODES transactions, one per cycle when result_ready stays high.
// Reset clears control state and colors; rows and weights are undefined until loaded.
module independent_set_graph_coloring #(
	parameter int NODES       = igc_pkg::DEF_NODES,
	parameter int WEIGHT_BITS = igc_pkg::DEF_WEIGHT_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  igc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output igc_pkg::result_t result
);

	localparam int ROW_W = (NODES < igc_pkg::MASK_W) ? NODES : igc_pkg::MASK_W;
	localparam int CW    = $clog2(NODES);
	localparam logic [CW-1:0] LAST_IDX = CW'(NODES - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROT  = 2'd1;
	localparam logic [1:0] ST_PICK = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     round_q;
	logic [CW-1:0]     step_q;
	logic [CW-1:0]     emit_q;
	logic              out_valid_q;
	igc_pkg::result_t  out_q;
	igc_pkg::cell_ctl_t ctl;
	logic              in_acc;
	logic              adv;
	logic              any_pick;

	logic [ROW_W-1:0]       rows    [NODES];
	logic [WEIGHT_BITS-1:0] weights [NODES];
	logic [CW-1:0]          colors  [NODES];
	logic [NODES-1:0]       picks;

	assign item_ready = (state_q == ST_IDLE);
	assign in_acc     = item_valid && item_ready;
	assign adv        = !out_valid_q || result_ready;
	assign any_pick   = |picks;

	always_comb begin
		ctl        = '0;
		ctl.load   = in_acc;
		ctl.start  = in_acc && item.last_node;
		ctl.rotate = (state_q == ST_ROT);
		ctl.pick   = (state_q == ST_PICK);
		ctl.drain  = (state_q == ST_EMIT) && adv;
	end

	genvar gi;
	generate
		for (gi = 0; gi < NODES; gi++) begin : g_cell
			localparam int LEFT  = (gi + NODES - 1) % NODES;
			logic [CW-1:0] right_color;
			if (gi == NODES - 1) begin : g_end
				assign right_color = '0;
			end else begin : g_mid
				assign right_color = colors[gi + 1];
			end
			igc_cell #(
				.NODES       (NODES),
				.WEIGHT_BITS (WEIGHT_BITS),
				.CELL        (gi)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.item        (item),
				.round       (round_q),
				.left_row    (rows[LEFT]),
				.left_weight (weights[LEFT]),
				.row         (rows[gi]),
				.weight      (weights[gi]),
				.right_color (right_color),
				.color       (colors[gi]),
				.pick        (picks[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			step_q  <= '0;
			emit_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_ROT;
						round_q <= CW'(1);
						step_q  <= '0;
					end
				end
				ST_ROT: begin
					step_q <= step_q + CW'(1);
					if (step_q == LAST_IDX) begin
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					step_q <= '0;
					if (any_pick && (round_q != LAST_IDX)) begin
						round_q <= round_q + CW'(1);
						state_q <= ST_ROT;
					end else begin
						emit_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (adv) begin
						emit_q <= emit_q + CW'(1);
						if (emit_q == LAST_IDX) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.drain) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			out_q.out_node    <= igc_pkg::IDX_W'(emit_q);
			out_q.node_color  <= igc_pkg::COLOR_W'(colors[0]);
			out_q.last_result <= (emit_q == LAST_IDX);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && item.last_node) |=> (state_q == ST_ROT && round_q == CW'(1)))
		else $error("coloring did not start after final load");

	a_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) |=> (state_q == ST_ROT || state_q == ST_EMIT))
		else $error("bad transition after pick");

	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_ready && !result.last_result) |-> (state_q == ST_EMIT))
		else $error("result sequence ended early");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.drain && emit_q == LAST_IDX) |=> (state_q == ST_IDLE))
		else $error("emission did not return to idle");

endmodule

// ----- sim/independent_set_graph_coloring_tb.sv -----
`timescale 1ns / 100ps

module independent_set_graph_coloring_tb;

	localparam int NODES = igc_pkg::DEF_NODES;
	localparam int RAND_ITEMS = 208;
	localparam int QUIET_AFTER = 170;

	typedef logic [NODES-1:0][igc_pkg::COLOR_W-1:0] color_vec_t;

	typedef struct {
		igc_pkg::item_t it;
		bit             typed;
		color_vec_t     cols;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	igc_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	igc_pkg::result_t result;

	logic [igc_pkg::MASK_W-1:0]   adj_row [NODES];
	logic [igc_pkg::WEIGHT_W-1:0] wt_val [NODES];
	logic [igc_pkg::COLOR_W-1:0]  col_val [NODES];

	igc_pkg::result_t color_exp [$];
	dir_row_t         dir_tab [$];
	int               mismatch_cnt = 0;
	int               stall_left = 0;
	int               rand_sent = 0;
	bit               quiet = 0;

	independent_set_graph_coloring uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #10 clk = ~clk;

	initial begin
		#10_000_000;
		$display("[independent_set_graph_coloring] ERROR");
		$finish;
	end

	function automatic igc_pkg::item_t mk_item(int idx, int mask, int wt, bit last);
		igc_pkg::item_t x;
		x.node_index    = idx[igc_pkg::IDX_W-1:0];
		x.neighbor_mask = mask[igc_pkg::MASK_W-1:0];
		x.node_weight   = wt[igc_pkg::WEIGHT_W-1:0];
		x.last_node     = last;
		return x;
	endfunction

	task automatic color_graph();
		logic [igc_pkg::WEIGHT_W-1:0] nmax;
		bit pick [NODES];
		int cnt;
		bit done;
		done = 0;
		for (int i = 0; i < NODES; i++)
			col_val[i] = '0;
		for (int c = 1; c < NODES; c++) begin
			if (!done) begin
				cnt = 0;
				for (int i = 0; i < NODES; i++) begin
					nmax = '0;
					for (int j = 0; j < NODES; j++)
						if (adj_row[j][i] && wt_val[j] > nmax)
							nmax = wt_val[j];
					pick[i] = wt_val[i] > nmax;
					if (pick[i])
						cnt++;
				end
				if (cnt == 0)
					done = 1;
				else
					for (int i = 0; i < NODES; i++)
						if (pick[i]) begin
							col_val[i] = c[igc_pkg::COLOR_W-1:0];
							wt_val[i] = '0;
						end
			end
		end
	endtask

	// called right after a rising edge
	task automatic load_node(input igc_pkg::item_t x, input bit typed,
			input color_vec_t cols);
		igc_pkg::result_t r;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do @(posedge clk); while (!item_ready);
		adj_row[x.node_index] = x.neighbor_mask;
		wt_val[x.node_index] = x.node_weight;
		if (x.last_node) begin
			color_graph();
			for (int i = 0; i < NODES; i++) begin
				r.out_node    = i[igc_pkg::IDX_W-1:0];
				r.node_color  = typed ? cols[i] : col_val[i];
				r.last_result = (i == NODES - 1);
				color_exp.push_back(r);
			end
		end
	endtask

	task automatic add_row(input igc_pkg::item_t x, input bit typed, input color_vec_t cols);
		dir_row_t d;
		d.it = x;
		d.typed = typed;
		d.cols = cols;
		dir_tab.push_back(d);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			result_ready <= 1'b0;
			stall_left <= $urandom_range(0, 16);
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		igc_pkg::result_t e;
		if (arst_n && result_valid && result_ready) begin
			if (color_exp.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result: node %0d color %0d last %0b",
						result.out_node, result.node_color, result.last_result);
			end else begin
				e = color_exp.pop_front();
				if (result.out_node !== e.out_node || result.node_color !== e.node_color ||
						result.last_result !== e.last_result) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display({"mismatch: exp node %0d color %0d last %0b,",
							" got node %0d color %0d last %0b"},
							e.out_node, e.node_color, e.last_result,
							result.out_node, result.node_color, result.last_result);
				end
			end
		end
	end

	initial begin
		int c_wts [NODES];
		int perm [NODES];
		logic [igc_pkg::MASK_W-1:0] g [NODES];
		int p, k, t, r, w, n;
		color_vec_t none;

		clk = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		none = '0;
		c_wts = '{1200, 65534, 33, 4096, 10, 800, 32768, 2};

		// empty graph, distinct weights: all take color 1
		add_row(mk_item(0, 8'h00, 16'hFFFF, 0), 0, none);
		for (int i = 1; i < NODES - 1; i++)
			add_row(mk_item(i, 8'h00, i + 1, 0), 0, none);
		add_row(mk_item(7, 8'h00, 1, 1), 1, {NODES{3'd1}});
		// self loop on the only weighted node: nobody qualifies
		add_row(mk_item(3, 8'hFF, 16'h8000, 1), 1, {NODES{3'd0}});
		// complete graph: one color per round, lowest weight left uncolored
		for (int i = NODES - 1; i >= 0; i--)
			add_row(mk_item(i, 8'hFF & ~(1 << i), c_wts[i], i == 0), 0, none);
		// equal weights on an edge
		add_row(mk_item(0, 8'h02, 500, 0), 0, none);
		add_row(mk_item(1, 8'h01, 500, 1), 0, none);
		// zero weight
		add_row(mk_item(5, 8'h00, 0, 1), 0, none);
		add_row(mk_item(7, 8'hFF, 16'hFFFF, 1), 0, none);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			load_node(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].cols);

		while (rand_sent < RAND_ITEMS) begin
			if (rand_sent >= QUIET_AFTER)
				quiet = 1;
			t = $urandom_range(0, 9);
			if (t <= 4 || t == 9) begin
				p = $urandom_range(0, 100);
				for (int i = 0; i < NODES; i++) begin
					g[i] = '0;
					perm[i] = i;
				end
				for (int i = 0; i < NODES; i++)
					for (int j = i + 1; j < NODES; j++)
						if ($urandom_range(0, 99) < p) begin
							g[i][j] = 1'b1;
							g[j][i] = 1'b1;
						end
				for (int i = 0; i < NODES; i++)
					if ($urandom_range(0, 15) == 0)
						g[i][i] = 1'b1;
				for (int i = NODES - 1; i > 0; i--) begin
					k = $urandom_range(0, i);
					n = perm[i];
					perm[i] = perm[k];
					perm[k] = n;
				end
				n = (t == 9) ? $urandom_range(1, NODES - 1) : NODES;
				for (int i = 0; i < n; i++) begin
					r = $urandom_range(0, 19);
					if (r == 0)
						w = 0;
					else if (r <= 3)
						w = $urandom_range(1, 3);
					else
						w = $urandom_range(1, 65535);
					load_node(mk_item(perm[i], g[perm[i]], w, (t != 9) && (i == n - 1)), 0, none);
					rand_sent++;
				end
			end else if (t <= 7) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) begin
					load_node(mk_item($urandom_range(0, NODES - 1), $urandom_range(0, 255),
						$urandom_range(0, 65535), i == n - 1), 0, none);
					rand_sent++;
				end
			end else begin
				load_node(mk_item($urandom_range(0, NODES - 1), $urandom_range(0, 255),
					$urandom_range(0, 65535), $urandom_range(0, 1)), 0, none);
				rand_sent++;
			end
		end
		// close any open sequence so the tail gets checked too
		load_node(mk_item($urandom_range(0, NODES - 1), $urandom_range(0, 255),
			$urandom_range(1, 65535), 1), 0, none);
		item_valid <= 1'b0;

		while (color_exp.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (mismatch_cnt == 0 && color_exp.size() == 0) begin
			$display("[independent_set_graph_coloring] OK");
		end else begin
			$display("[independent_set_graph_coloring] ERROR");
		end
		$finish;
	end

endmodule
